@@ src/small_matrix_arith_engine_top_assert.svh @@
// assertion macros for the small matrix arithmetic engine checker
// used by smae_checker.sv, no other dependencies
`ifndef SMALL_MATRIX_ARITH_ENGINE_TOP_ASSERT_SVH
`define SMALL_MATRIX_ARITH_ENGINE_TOP_ASSERT_SVH

// clocked property, masked while reset is high
`define SMAE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset too
`define SMAE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/smae_pkg.sv @@
// shared types and constants for the small matrix arithmetic engine
// no dependencies
package smae_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int POS_W       = 3;
  localparam int DATA_W      = 32;
  localparam int DIMREG_W    = 4;
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 3;

  // operation codes held in op_mode
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_TRA = 3'd3,
    OP_TRB = 3'd4
  } op_mode_t;

  // request action codes
  localparam logic [1:0] ACT_WR_A  = 2'd0;
  localparam logic [1:0] ACT_WR_B  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B  = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } seq_state_t;

  // one issued term for the multiply-accumulate unit
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

@@ src/smae_store.sv @@
// element storage for matrices a and b, one write and one registered read each
// depends on smae_pkg for its default size
module smae_store #(
  parameter int MAX_DIM = smae_pkg::MAX_DIM_DEF,
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int DEPTH  = MAX_DIM * MAX_DIM,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              a_we,
  input  logic              b_we,
  input  logic [IDX_W-1:0]  w_row,
  input  logic [IDX_W-1:0]  w_col,
  input  logic [31:0]       w_data,
  input  logic [IDX_W-1:0]  a_row,
  input  logic [IDX_W-1:0]  a_col,
  input  logic [IDX_W-1:0]  b_row,
  input  logic [IDX_W-1:0]  b_col,
  output logic [31:0]       a_rdata,
  output logic [31:0]       b_rdata
);

  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];
  logic [ADDR_W-1:0] w_addr, a_addr, b_addr;

  assign w_addr = ADDR_W'(int'(w_row) * MAX_DIM + int'(w_col));
  assign a_addr = ADDR_W'(int'(a_row) * MAX_DIM + int'(a_col));
  assign b_addr = ADDR_W'(int'(b_row) * MAX_DIM + int'(b_col));

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[w_addr] <= w_data;
    end
    if (b_we) begin
      mem_b[w_addr] <= w_data;
    end
    a_rdata <= mem_a[a_addr];
    b_rdata <= mem_b[b_addr];
  end

endmodule

@@ src/smae_alu.sv @@
// shared arithmetic unit: combine stage (add, sub, multiply, pass) and accumulator
// depends on smae_pkg
module smae_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            op,
  input  smae_pkg::mac_ctrl_t   issue,
  input  logic [31:0]           a_rdata,
  input  logic [31:0]           b_rdata,
  output logic                  done,
  output logic [31:0]           acc
);

  smae_pkg::mac_ctrl_t rd_ctrl, p_ctrl;
  logic [31:0] prod, prod_next, acc_next;

  always_comb begin
    case (op)
      smae_pkg::OP_ADD: prod_next = a_rdata + b_rdata;
      smae_pkg::OP_SUB: prod_next = a_rdata - b_rdata;
      smae_pkg::OP_MUL: prod_next = 32'(a_rdata * b_rdata);
      smae_pkg::OP_TRA: prod_next = a_rdata;
      smae_pkg::OP_TRB: prod_next = b_rdata;
      default:          prod_next = '0;
    endcase
  end

  assign acc_next = (p_ctrl.first ? 32'd0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl <= '0;
      p_ctrl  <= '0;
      done    <= 1'b0;
    end else begin
      rd_ctrl <= issue;
      p_ctrl  <= rd_ctrl;
      done    <= p_ctrl.vld & p_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_ctrl.vld) begin
      prod <= prod_next;
    end
    if (p_ctrl.vld) begin
      acc <= acc_next;
    end
  end

endmodule

@@ src/smae_seq.sv @@
// sequencer: walks result elements and inner terms, owns the result register
// depends on smae_pkg
module smae_seq #(
  parameter int MAX_DIM = smae_pkg::MAX_DIM_DEF,
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           op_mode,
  input  logic [DIM_W-1:0]     ra,
  input  logic [DIM_W-1:0]     ca,
  input  logic [DIM_W-1:0]     rb,
  input  logic [DIM_W-1:0]     cb,
  output logic                 idle,
  output logic [2:0]           alu_op,
  output smae_pkg::mac_ctrl_t  issue,
  output logic [IDX_W-1:0]     a_row,
  output logic [IDX_W-1:0]     a_col,
  output logic [IDX_W-1:0]     b_row,
  output logic [IDX_W-1:0]     b_col,
  input  logic                 done,
  input  logic [31:0]          acc,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           res_row,
  output logic [2:0]           res_col,
  output logic signed [31:0]   res_value,
  output logic                 status,
  output logic                 last
);

  smae_pkg::seq_state_t state, state_next;
  logic [2:0]       op_r, op_r_next;
  logic [DIM_W-1:0] nr, nr_next, nc, nc_next, kn, kn_next;
  logic [IDX_W-1:0] i, i_next, j, j_next, k, k_next;
  logic             out_valid_next, out_free, load;
  logic [2:0]       ld_row, ld_col;
  logic [31:0]      ld_value;
  logic             ld_status, ld_last;
  logic             st_err;
  logic [DIM_W-1:0] st_nr, st_nc, st_kn;
  logic             row_end, col_end;

  assign idle     = (state == smae_pkg::ST_IDLE);
  assign alu_op   = op_r;
  assign out_free = !out_valid || out_ready;
  assign col_end  = (DIM_W'(j) + DIM_W'(1)) == nc;
  assign row_end  = (DIM_W'(i) + DIM_W'(1)) == nr;

  // result shape and dimension check for a start request
  always_comb begin
    st_err = 1'b0;
    st_nr  = ra;
    st_nc  = ca;
    st_kn  = DIM_W'(1);
    case (op_mode)
      smae_pkg::OP_ADD, smae_pkg::OP_SUB: begin
        st_err = (ra != rb) || (ca != cb);
      end
      smae_pkg::OP_MUL: begin
        st_err = (ca != rb);
        st_nc  = cb;
        st_kn  = ca;
      end
      smae_pkg::OP_TRA: begin
        st_nr = ca;
        st_nc = ra;
      end
      smae_pkg::OP_TRB: begin
        st_nr = cb;
        st_nc = rb;
      end
      default: st_err = 1'b1;
    endcase
  end

  // read addresses for the current term
  always_comb begin
    a_row = i;
    a_col = j;
    b_row = i;
    b_col = j;
    case (op_r)
      smae_pkg::OP_MUL: begin
        a_col = k;
        b_row = k;
      end
      smae_pkg::OP_TRA, smae_pkg::OP_TRB: begin
        a_row = j;
        a_col = i;
        b_row = j;
        b_col = i;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    op_r_next  = op_r;
    nr_next    = nr;
    nc_next    = nc;
    kn_next    = kn;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    issue      = '0;
    load       = 1'b0;
    ld_row     = 3'(i);
    ld_col     = 3'(j);
    ld_value   = acc;
    ld_status  = smae_pkg::STATUS_OK;
    ld_last    = row_end && col_end;
    case (state)
      smae_pkg::ST_IDLE: begin
        if (start) begin
          op_r_next  = op_mode;
          nr_next    = st_nr;
          nc_next    = st_nc;
          kn_next    = st_kn;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = st_err ? smae_pkg::ST_ERR : smae_pkg::ST_RUN;
        end
      end
      smae_pkg::ST_ERR: begin
        ld_row    = '0;
        ld_col    = '0;
        ld_value  = '0;
        ld_status = smae_pkg::STATUS_ERR;
        ld_last   = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = smae_pkg::ST_IDLE;
        end
      end
      smae_pkg::ST_RUN: begin
        issue.vld   = 1'b1;
        issue.first = (k == '0);
        issue.last  = (DIM_W'(k) + DIM_W'(1)) == kn;
        if (issue.last) begin
          k_next     = '0;
          state_next = smae_pkg::ST_WAIT;
        end else begin
          k_next = IDX_W'(k + IDX_W'(1));
        end
      end
      smae_pkg::ST_WAIT: begin
        if (done) begin
          state_next = smae_pkg::ST_EMIT;
        end
      end
      smae_pkg::ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (row_end && col_end) begin
            state_next = smae_pkg::ST_IDLE;
          end else begin
            state_next = smae_pkg::ST_RUN;
            if (col_end) begin
              j_next = '0;
              i_next = IDX_W'(i + IDX_W'(1));
            end else begin
              j_next = IDX_W'(j + IDX_W'(1));
            end
          end
        end
      end
      default: state_next = smae_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smae_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_r_next;
    nr   <= nr_next;
    nc   <= nc_next;
    kn   <= kn_next;
    i    <= i_next;
    j    <= j_next;
    k    <= k_next;
    if (load) begin
      res_row   <= ld_row;
      res_col   <= ld_col;
      res_value <= ld_value;
      status    <= ld_status;
      last      <= ld_last;
    end
  end

endmodule

@@ src/small_matrix_arith_engine_top.sv @@
// top level of the small matrix arithmetic engine
// depends on smae_pkg, smae_store, smae_alu, smae_seq
//
// usage
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
//     index 0 op_mode, 1 rows_a, 2 cols_a, 3 rows_b, 4 cols_b; write only while idle
//   request channel (in_valid/in_ready): action 0 writes a[row][col], action 1
//     writes b[row][col], action 2 starts the configured operation
//   result channel (out_valid/out_ready): res_row, res_col, res_value, status,
//     last; one element per transfer, row-major, last marks the final one
//   writes are taken only while idle; in_ready stays low from a start until the final
//     result of that operation has been loaded into the result register
//   each element takes kn terms, kn = cols_a for multiply and 1 otherwise:
//     one term per cycle through the shared multiply-accumulate unit, then its
//     read, combine and accumulate stages and the load of the result register
//   a dimension mismatch or an undefined op_mode gives a single error result
//   a stalled receiver holds the result register and the sequencer waits;
//     writes are still taken while the last result waits
//   reset returns op_mode to add and all dimensions to 1; store contents
//     are undefined until written
module small_matrix_arith_engine_top #(
  parameter int MAX_DIM = smae_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      action,
  input  logic [2:0]                      row,
  input  logic [2:0]                      col,
  input  logic signed [31:0]              value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      res_row,
  output logic [2:0]                      res_col,
  output logic signed [31:0]              res_value,
  output logic                            status,
  output logic                            last,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smae_pkg::DIMREG_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  // configuration registers
  logic [smae_pkg::OP_W-1:0]     op_mode;
  logic [smae_pkg::DIMREG_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [DIM_W-1:0] ra, ca, rb, cb;

  logic in_acc, wr_ok, a_we, b_we, start, idle;
  logic [2:0] alu_op;
  smae_pkg::mac_ctrl_t issue;
  logic [IDX_W-1:0] a_row, a_col, b_row, b_col;
  logic [31:0] a_rdata, b_rdata, acc;
  logic done;

  // dimension register of 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [smae_pkg::DIMREG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= smae_pkg::OP_ADD;
      rows_a  <= smae_pkg::DIMREG_W'(1);
      cols_a  <= smae_pkg::DIMREG_W'(1);
      rows_b  <= smae_pkg::DIMREG_W'(1);
      cols_b  <= smae_pkg::DIMREG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        smae_pkg::CFG_OP_MODE: op_mode <= cfg_data[smae_pkg::OP_W-1:0];
        smae_pkg::CFG_ROWS_A:  rows_a  <= cfg_data;
        smae_pkg::CFG_COLS_A:  cols_a  <= cfg_data;
        smae_pkg::CFG_ROWS_B:  rows_b  <= cfg_data;
        smae_pkg::CFG_COLS_B:  cols_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ra = eff_dim(rows_a);
  assign ca = eff_dim(cols_a);
  assign rb = eff_dim(rows_b);
  assign cb = eff_dim(cols_b);

  // request decode; writes outside the store are dropped, unused action ignored
  assign in_ready = idle;
  assign in_acc   = in_valid && in_ready;
  assign wr_ok    = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign a_we     = in_acc && (action == smae_pkg::ACT_WR_A) && wr_ok;
  assign b_we     = in_acc && (action == smae_pkg::ACT_WR_B) && wr_ok;
  assign start    = in_acc && (action == smae_pkg::ACT_START);

  smae_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk     (clk),
    .a_we    (a_we),
    .b_we    (b_we),
    .w_row   (row[IDX_W-1:0]),
    .w_col   (col[IDX_W-1:0]),
    .w_data  (value),
    .a_row   (a_row),
    .a_col   (a_col),
    .b_row   (b_row),
    .b_col   (b_col),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata)
  );

  // shared multiply-accumulate unit, three stages behind the issue
  smae_alu u_alu (
    .clk     (clk),
    .rst     (rst),
    .op      (alu_op),
    .issue   (issue),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .done    (done),
    .acc     (acc)
  );

  smae_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op_mode   (op_mode),
    .ra        (ra),
    .ca        (ca),
    .rb        (rb),
    .cb        (cb),
    .idle      (idle),
    .alu_op    (alu_op),
    .issue     (issue),
    .a_row     (a_row),
    .a_col     (a_col),
    .b_row     (b_row),
    .b_col     (b_col),
    .done      (done),
    .acc       (acc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_value (res_value),
    .status    (status),
    .last      (last)
  );

endmodule

@@ src/smae_checker.sv @@
// port-level checks for the small matrix arithmetic engine, bound to the top level
// depends on smae_pkg and small_matrix_arith_engine_top_assert.svh
`include "small_matrix_arith_engine_top_assert.svh"

module smae_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      action,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      res_row,
  input logic [2:0]                      res_col,
  input logic signed [31:0]              res_value,
  input logic                            status,
  input logic                            last
);

  logic err_clear;

  // error result fields all cleared and marked as the final one
  assign err_clear = last && (res_row == 3'd0) && (res_col == 3'd0) && (res_value == 32'sd0);

  // a waiting result is not withdrawn
  `SMAE_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // an error result is marked as the final one and has cleared fields
  `SMAE_ASSERT(a_err_shape, clk, rst, out_valid && status |-> err_clear, "bad error result")

  // an accepted start request is followed by in_ready low
  `SMAE_ASSERT(a_start_busy, clk, rst, in_valid && in_ready && action == smae_pkg::ACT_START |=> !in_ready, "ready during operation")

  // reset empties the result register
  `SMAE_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "result after reset")

endmodule

bind small_matrix_arith_engine_top smae_checker u_smae_checker (.*);

@@ tb/smae_result_checker.sv @@
`timescale 1ns / 100ps
// scoreboard for the small matrix arithmetic engine: mirrors both element stores and
// the register file, predicts every result element and compares; depends on smae_pkg
module smae_result_checker
  import smae_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          action,
  input  logic [2:0]          row,
  input  logic [2:0]          col,
  input  logic [31:0]         value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [2:0]          res_row,
  input  logic [2:0]          res_col,
  input  logic [31:0]         res_value,
  input  logic                status,
  input  logic                last,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIMREG_W-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);

  typedef struct packed {
    logic [2:0]  row_i;
    logic [2:0]  col_i;
    logic [31:0] data;
    logic        err;
    logic        fin;
  } elem_t;

  elem_t       elem_q[$];
  logic [31:0] a_elems[64];
  logic [31:0] b_elems[64];
  logic [2:0]  mode_q;
  logic [3:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;

  // zero reads as one, oversize reads as the largest side
  function automatic int dim_eff(logic [3:0] d);
    if (d == 4'd0) return 1;
    if (int'(d) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic queue_results();
    int          ra, ca, rb, cb, nr, nc;
    bit          bad;
    logic [31:0] acc;
    elem_t       e;
    ra = dim_eff(rows_a_q);
    ca = dim_eff(cols_a_q);
    rb = dim_eff(rows_b_q);
    cb = dim_eff(cols_b_q);
    bad = 1'b0;
    nr = 0;
    nc = 0;
    case (mode_q)
      OP_ADD, OP_SUB: begin
        bad = (ra != rb) || (ca != cb);
        nr = ra;
        nc = ca;
      end
      OP_MUL: begin
        bad = (ca != rb);
        nr = ra;
        nc = cb;
      end
      OP_TRA: begin
        nr = ca;
        nc = ra;
      end
      OP_TRB: begin
        nr = cb;
        nc = rb;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      e = '{row_i: 3'd0, col_i: 3'd0, data: 32'd0, err: STATUS_ERR, fin: 1'b1};
      elem_q.push_back(e);
      return;
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        case (mode_q)
          OP_ADD: acc = a_elems[i*8+j] + b_elems[i*8+j];
          OP_SUB: acc = a_elems[i*8+j] - b_elems[i*8+j];
          OP_MUL: begin
            acc = '0;
            for (int k = 0; k < ca; k++) acc += a_elems[i*8+k] * b_elems[k*8+j];
          end
          OP_TRA: acc = a_elems[j*8+i];
          default: acc = b_elems[j*8+i];
        endcase
        e.row_i = 3'(i);
        e.col_i = 3'(j);
        e.data  = acc;
        e.err   = STATUS_OK;
        e.fin   = (i == nr - 1) && (j == nc - 1);
        elem_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    elem_t want;
    if (rst) begin
      elem_q.delete();
      errors   = 0;
      mode_q   = OP_ADD;
      rows_a_q = 4'd1;
      cols_a_q = 4'd1;
      rows_b_q = 4'd1;
      cols_b_q = 4'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OP_MODE: mode_q   = cfg_data[2:0];
          CFG_ROWS_A:  rows_a_q = cfg_data;
          CFG_COLS_A:  cols_a_q = cfg_data;
          CFG_ROWS_B:  rows_b_q = cfg_data;
          CFG_COLS_B:  cols_b_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (elem_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result row %0d col %0d value %h status %b last %b",
                   $time, res_row, res_col, res_value, status, last);
        end else begin
          want = elem_q.pop_front();
          check_field("res_row", 32'(want.row_i), 32'(res_row));
          check_field("res_col", 32'(want.col_i), 32'(res_col));
          check_field("res_value", want.data, res_value);
          check_field("status", 32'(want.err), 32'(status));
          check_field("last", 32'(want.fin), 32'(last));
        end
      end
      if (in_valid && in_ready) begin
        case (action)
          ACT_WR_A:  a_elems[{row, col}] = value;
          ACT_WR_B:  b_elems[{row, col}] = value;
          ACT_START: queue_results();
          default: ;
        endcase
      end
    end
    pending <= elem_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the small matrix arithmetic engine
// depends on smae_pkg, small_matrix_arith_engine_top and smae_result_checker
module tb;
  import smae_pkg::*;

  localparam int         QUIET_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int         HOLD_CYCLES   = 300;   // long receiver back-pressure
  localparam int         SETTLE_CYCLES = 12;    // settling time after the last predicted result
  localparam int         RAND_ITEMS    = 320;
  localparam logic [1:0] ACT_NONE      = 2'd3;  // action the block ignores

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [1:0]           action    = ACT_WR_A;
  logic [2:0]           row       = 3'd0;
  logic [2:0]           col       = 3'd0;
  logic signed [31:0]   value     = 32'sd0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OP_MODE;
  logic [DIMREG_W-1:0]  cfg_data  = 4'd0;
  logic                 in_ready, out_valid, status, last, cfg_ready;
  logic [2:0]           res_row, res_col;
  logic signed [31:0]   res_value;
  int                   errors, pending;

  // stimulus-side view of the register file, so starts never read unwritten entries
  logic [2:0] mode_now   = OP_ADD;
  logic [3:0] rows_a_now = 4'd1;
  logic [3:0] cols_a_now = 4'd1;
  logic [3:0] rows_b_now = 4'd1;
  logic [3:0] cols_b_now = 4'd1;
  bit         wr_a[64];
  bit         wr_b[64];

  bit calm      = 1'b0;  // no idling on either side
  int hold_ask  = 0;     // bumped by the stimulus to ask for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int quiet     = 0;
  int items     = 0;     // requests accepted, ignored actions excluded

  small_matrix_arith_engine_top DUT (.*);
  smae_result_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, a long hold-off on demand, full speed while calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      out_ready <= 1'b0;
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // watchdog: any channel moving resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int span(logic [3:0] d);
    if (d == 4'd0) return 1;
    if (int'(d) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  // element values lean on the wrap points
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // mostly small sides, sometimes the full one, now and then out of range
  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 4'd8;
      1: return 4'($urandom_range(0, 15));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // one request; valid goes low only when this request idles first, and is not
  // dropped after acceptance so back-to-back requests keep it high
  task automatic send_req(input logic [1:0] a, input logic [2:0] r, input logic [2:0] c,
                          input logic [31:0] v);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 37);
    end
    in_valid <= 1'b1;
    action   <= a;
    row      <= r;
    col      <= c;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (a != ACT_NONE) items++;
  endtask

  task automatic write_el(input logic [1:0] which, input int r, input int c,
                          input logic [31:0] v);
    send_req(which, 3'(r), 3'(c), v);
    if (which == ACT_WR_A) wr_a[r*8+c] = 1'b1;
    else wr_b[r*8+c] = 1'b1;
  endtask

  // write whatever the coming start will read and has never been written
  task automatic fill_region(input logic [1:0] which, input int nr, input int nc);
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (which == ACT_WR_A ? !wr_a[r*8+c] : !wr_b[r*8+c]) write_el(which, r, c, rand_val());
      end
    end
  endtask

  task automatic launch();
    int ra, ca, rb, cb;
    ra = span(rows_a_now);
    ca = span(cols_a_now);
    rb = span(rows_b_now);
    cb = span(cols_b_now);
    case (mode_now)
      OP_ADD, OP_SUB: begin
        if (ra == rb && ca == cb) begin
          fill_region(ACT_WR_A, ra, ca);
          fill_region(ACT_WR_B, rb, cb);
        end
      end
      OP_MUL: begin
        if (ca == rb) begin
          fill_region(ACT_WR_A, ra, ca);
          fill_region(ACT_WR_B, rb, cb);
        end
      end
      OP_TRA: fill_region(ACT_WR_A, ra, ca);
      OP_TRB: fill_region(ACT_WR_B, rb, cb);
      default: ;
    endcase
    // position and value mean nothing on a start, so they stay random
    send_req(ACT_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
  endtask

  // register write; only called while the block is idle
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIMREG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OP_MODE: mode_now   = d[2:0];
      CFG_ROWS_A:  rows_a_now = d;
      CFG_COLS_A:  cols_a_now = d;
      CFG_ROWS_B:  rows_b_now = d;
      CFG_COLS_B:  cols_b_now = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending, let every predicted element drain, then let the block settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new operation and shape; dimensions usually agree so results stream out
  task automatic reshape();
    logic [3:0] md, ra, ca, rb, cb;
    md = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4));
    ra = pick_dim();
    ca = pick_dim();
    rb = pick_dim();
    cb = pick_dim();
    if ((md[2:0] == OP_ADD || md[2:0] == OP_SUB) && $urandom_range(0, 4) != 0) begin
      rb = ra;
      cb = ca;
    end else if (md[2:0] == OP_MUL && $urandom_range(0, 4) != 0) begin
      rb = ca;
    end
    set_reg(CFG_OP_MODE, md);
    set_reg(CFG_ROWS_A, ra);
    set_reg(CFG_COLS_A, ca);
    set_reg(CFG_ROWS_B, rb);
    set_reg(CFG_COLS_B, cb);
    // indexes past the register file should be dropped
    if ($urandom_range(0, 9) == 0) set_reg(CFG_IDX_W'($urandom_range(5, 7)), 4'($urandom));
  endtask

  initial begin : stimulus
    int ops, base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // add at reset shape, positive wrap
    write_el(ACT_WR_A, 0, 0, 32'h7fff_ffff);
    write_el(ACT_WR_B, 0, 0, 32'h0000_0001);
    launch();
    // subtract, negative wrap
    quiesce();
    set_reg(CFG_OP_MODE, 4'(OP_SUB));
    write_el(ACT_WR_A, 0, 0, 32'h8000_0000);
    launch();
    // most negative times minus one wraps back to itself
    quiesce();
    set_reg(CFG_OP_MODE, 4'(OP_MUL));
    write_el(ACT_WR_B, 0, 0, 32'hffff_ffff);
    launch();
    // inner dimensions disagree
    quiesce();
    set_reg(CFG_COLS_A, 4'd3);
    set_reg(CFG_ROWS_B, 4'd2);
    launch();
    // undefined operation code and an index past the register file
    quiesce();
    set_reg(CFG_OP_MODE, 4'd7);
    set_reg(CFG_IDX_W'(7), 4'hf);
    launch();
    // transpose of a with a zero and an oversize side
    quiesce();
    set_reg(CFG_OP_MODE, 4'(OP_TRA));
    set_reg(CFG_ROWS_A, 4'd0);
    set_reg(CFG_COLS_A, 4'd15);
    launch();
    // transpose of b with a zero side
    quiesce();
    set_reg(CFG_OP_MODE, 4'(OP_TRB));
    set_reg(CFG_ROWS_B, 4'd0);
    launch();
    // add with unequal shapes
    quiesce();
    set_reg(CFG_OP_MODE, 4'(OP_ADD));
    launch();
    // ignored action, far corner writes
    send_req(ACT_NONE, 3'd7, 3'd7, 32'hffff_ffff);
    write_el(ACT_WR_A, 7, 7, 32'h8000_0000);
    write_el(ACT_WR_B, 7, 7, 32'h7fff_ffff);

    // random operations: a few stray writes, fill what the start reads, then start
    ops  = 0;
    base = items;
    while (items - base < RAND_ITEMS) begin
      if (ops % 3 == 0 || $urandom_range(0, 3) == 0) begin
        quiesce();
        reshape();
      end
      calm = (items - base >= 140) && (items - base < 200);
      // long receiver hold-off while requests keep coming
      if (ops == 6 || ops == 40) hold_ask++;
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 19) == 0) begin
          send_req(ACT_NONE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
        end else begin
          write_el($urandom_range(0, 1) ? ACT_WR_B : ACT_WR_A, $urandom_range(0, 7),
                   $urandom_range(0, 7), rand_val());
        end
      end
      launch();
      ops++;
    end
    calm = 1'b0;

    quiesce();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
